[hw/rtl/fngq_pkg.sv]
// ----------------------------------------------------------------------------
// fngq_pkg: shared types and constants of the narrow grid quantizer
// Format codes, grid descriptors and the grid lookup function.
// ----------------------------------------------------------------------------
package fngq_pkg;

	localparam int unsigned FMT_W  = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [FMT_W-1:0] {
		FMT_E4M3FN      = 4'd0,
		FMT_E5M2        = 4'd1,
		FMT_E4M3        = 4'd2,
		FMT_E3M4        = 4'd3,
		FMT_E8M0        = 4'd4,
		FMT_E4M3B11FNUZ = 4'd5,
		FMT_E5M2FNUZ    = 4'd6,
		FMT_E4M3FNUZ    = 4'd7,
		FMT_E2M3        = 4'd8,
		FMT_E3M2        = 4'd9,
		FMT_E2M1        = 4'd10,
		FMT_INT4        = 4'd11,
		FMT_UINT4       = 4'd12,
		FMT_RSV13       = 4'd13,
		FMT_RSV14       = 4'd14,
		FMT_RSV15       = 4'd15
	} fmt_t;

	typedef enum logic [1:0] {
		OV_NAN = 2'd0,
		OV_INF = 2'd1,
		OV_SAT = 2'd2
	} ovf_t;

	typedef struct packed {
		logic [2:0]  man;       // mantissa bits
		logic [7:0]  tiny_be;   // biased exponent of smallest normal
		logic [31:0] max_bits;  // largest finite magnitude
		ovf_t        over;
	} grid_t;

	// Result class picked by the format decode
	typedef enum logic [1:0] {
		PATH_FLT  = 2'd0,
		PATH_E8M0 = 2'd1,
		PATH_INT  = 2'd2,
		PATH_PASS = 2'd3
	} path_t;

	// Decoded control carried with the item into the datapath
	typedef struct packed {
		path_t path;
		logic  sgn_ext;  // int4 rather than uint4
		grid_t grid;
	} ctl_t;

	localparam logic [31:0] EXP_INF   = 32'h7F80_0000;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] E8M0_MIN  = 32'h0040_0000;
	localparam logic [22:0] SQRT2_MAN = 23'h3504F4;

	function automatic grid_t grid_of(input fmt_t f);
		grid_t g;
		g = '{man: 3'd3, tiny_be: 8'd121, max_bits: 32'h43E0_0000, over: OV_NAN};
		unique case (f)
			FMT_E4M3FN:      g = '{3'd3, 8'd121, 32'h43E0_0000, OV_NAN};
			FMT_E5M2:        g = '{3'd2, 8'd113, 32'h4760_0000, OV_INF};
			FMT_E4M3:        g = '{3'd3, 8'd121, 32'h4370_0000, OV_INF};
			FMT_E3M4:        g = '{3'd4, 8'd125, 32'h4178_0000, OV_INF};
			FMT_E4M3B11FNUZ: g = '{3'd3, 8'd117, 32'h41F0_0000, OV_NAN};
			FMT_E5M2FNUZ:    g = '{3'd2, 8'd112, 32'h4760_0000, OV_NAN};
			FMT_E4M3FNUZ:    g = '{3'd3, 8'd120, 32'h4370_0000, OV_NAN};
			FMT_E2M3:        g = '{3'd3, 8'd127, 32'h40F0_0000, OV_SAT};
			FMT_E3M2:        g = '{3'd2, 8'd125, 32'h41E0_0000, OV_SAT};
			FMT_E2M1:        g = '{3'd1, 8'd127, 32'h40C0_0000, OV_SAT};
			default:         g = '{3'd3, 8'd121, 32'h43E0_0000, OV_NAN};
		endcase
		return g;
	endfunction

endpackage

[hw/rtl/fngq_decode.sv]
// ----------------------------------------------------------------------------
// fngq_decode: format register decode
// Turns the format code into grid descriptor and path select.
// ----------------------------------------------------------------------------
module fngq_decode import fngq_pkg::*; (
	input  logic [FMT_W-1:0] fmt,
	output ctl_t             ctl
);

	fmt_t f;
	assign f = fmt_t'(fmt);

	always_comb begin
		ctl.grid    = grid_of(f);
		ctl.sgn_ext = (f == FMT_INT4);
		unique case (f)
			FMT_E8M0:               ctl.path = PATH_E8M0;
			FMT_INT4, FMT_UINT4:    ctl.path = PATH_INT;
			FMT_RSV13, FMT_RSV14,
			FMT_RSV15:              ctl.path = PATH_PASS;
			default:                ctl.path = PATH_FLT;
		endcase
	end

endmodule

[hw/rtl/fngq_core.sv]
// ----------------------------------------------------------------------------
// fngq_core: quantizer datapath
// Combinational rounding onto the selected grid, E8M0 and int4/uint4 paths; reserved codes pass through.
// ----------------------------------------------------------------------------
module fngq_core import fngq_pkg::*; (
	input  logic [DATA_W-1:0] x,
	input  ctl_t              ctl,
	output logic [DATA_W-1:0] y
);

	logic        neg, is_nan;
	logic [30:0] a;
	logic [7:0]  be;
	logic [23:0] m;

	assign neg    = x[31];
	assign a      = x[30:0];
	assign be     = x[30:23];
	assign is_nan = (a > EXP_INF[30:0]);
	assign m      = (be == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};

	// ---------------- float grid path ----------------
	logic [31:0] q_flt, q_sub, q_nrm, f_res;
	logic [4:0]  shift;
	logic [31:0] lsb_mask, half;
	logic        lsb;
	logic [7:0]  eeff;   // biased exponent treating subnormal as 1
	logic [8:0]  sexp;   // biased exponent of step (tiny_be - man), may be <1
	logic [8:0]  r9;
	logic [5:0]  r;
	logic [24:0] kk;
	logic [23:0] remv, halfv, mask24;
	logic        rnd_up;
	logic [4:0]  p;
	logic [22:0] smant;

	assign shift    = 5'd23 - {2'b0, ctl.grid.man};
	assign lsb_mask = (32'd1 << shift) - 32'd1;
	assign half     = (32'd1 << (shift - 5'd1)) - 32'd1;
	assign lsb      = x[shift];
	assign q_nrm    = (x + half + {31'd0, lsb}) & ~lsb_mask;

	// subnormal grid: step = 2^(tiny - man); r = s - e
	assign eeff = (be == 8'd0) ? 8'd1 : be;
	assign sexp = {1'b0, ctl.grid.tiny_be} - {6'd0, ctl.grid.man};
	// r = (sexp-127) - (eeff-150) = sexp - eeff + 23
	assign r9   = sexp - {1'b0, eeff} + 9'd23;
	// shifts past 25 leave nothing, so they map to the no-step case
	assign r    = (r9 <= 9'd25) ? r9[5:0] : 6'd0;

	always_comb begin
		mask24 = 24'd0;
		halfv  = 24'd0;
		kk     = 25'd0;
		if (r >= 6'd1 && r <= 6'd24) begin
			mask24 = (24'd1 << r[4:0]) - 24'd1;
			halfv  = 24'd1 << (r[4:0] - 5'd1);
			kk     = {1'b0, m >> r[4:0]};
		end else if (r == 6'd25) begin
			mask24 = 24'hFF_FFFF;
			halfv  = 24'h80_0000 >> 0;
			halfv  = 24'd0;
			kk     = 25'd0;
		end
		remv = m & mask24;
		if (r == 6'd25) begin
			// half = 2^24 exceeds any m, never rounds up
			rnd_up = 1'b0;
		end else begin
			rnd_up = (r >= 6'd1 && r <= 6'd24) &&
				((remv > halfv) || (remv == halfv && kk[0]));
		end
		kk = kk + {24'd0, rnd_up};
	end

	// k is at most 2^4 (man<=4): leading one among few bits
	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 6; i++) begin
			if (kk[i]) p = 5'(i);
		end
	end

	assign smant = 23'((kk[22:0] << (5'd23 - p)));
	assign q_sub = (kk == 25'd0) ? {neg, 31'd0} :
		{neg, 8'(sexp[7:0] + {3'd0, p}), smant};

	assign q_flt = ({1'b0, a} < {1'b0, ctl.grid.tiny_be, 23'd0}) ? q_sub : q_nrm;

	always_comb begin
		f_res = q_flt;
		if (q_flt[30:0] > ctl.grid.max_bits[30:0]) begin
			unique case (ctl.grid.over)
				OV_INF:  f_res = {neg, EXP_INF[30:0]};
				OV_SAT:  f_res = {neg, ctl.grid.max_bits[30:0]};
				default: f_res = {neg, QNAN_BITS[30:0]};
			endcase
		end
		if (is_nan) f_res = x;
	end

	// ---------------- E8M0 path ----------------
	logic [31:0] e_res;
	logic [4:0]  tp;
	logic [22:0] em;
	logic [8:0]  ee;   // biased exponent, before sqrt2 bump
	logic [9:0]  ee2;

	always_comb begin
		tp = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) tp = 5'(i);
		end
	end

	// biased e = (eeff - 150) + tp + 127 = eeff + tp - 23
	assign em  = 23'(m << (5'd23 - tp));
	assign ee  = {1'b0, eeff} + {4'd0, tp} - 9'd23;
	assign ee2 = {ee[8], ee} + {9'd0, (em >= SQRT2_MAN)};

	always_comb begin
		if (is_nan)                     e_res = x;
		else if (neg || x == 32'd0)     e_res = E8M0_MIN;
		else if (x == EXP_INF)          e_res = EXP_INF;
		else if (ee2[9] || ee2 == 10'd0) e_res = E8M0_MIN;
		else if (ee2 >= 10'd255)        e_res = EXP_INF;
		else                            e_res = {1'b0, ee2[7:0], 23'd0};
	end

	// ---------------- integer path ----------------
	// Only low 4 bits of the truncated int32 matter.
	logic [31:0] i_res;
	logic [3:0]  mag4, low4;
	logic [5:0]  ie;   // be - 127 when be >= 127

	assign ie = 6'(be - 8'd127);

	always_comb begin
		mag4 = 4'd0;
		if (ie >= 6'd23) mag4 = 4'((m << (ie - 6'd23)));
		else             mag4 = 4'(m >> (6'd23 - ie));
		if (is_nan || be < 8'd127) low4 = 4'd0;
		else if (be >= 8'd158)     low4 = neg ? 4'd0 : 4'hF;
		else                       low4 = neg ? (4'd0 - mag4) : mag4;
		i_res = {{28{ctl.sgn_ext & low4[3]}}, low4};
	end

	always_comb begin
		unique case (ctl.path)
			PATH_FLT:  y = f_res;
			PATH_E8M0: y = e_res;
			PATH_INT:  y = i_res;
			default:   y = x;
		endcase
	end

endmodule

[hw/rtl/float32_to_narrow_grid_quantizer_unit.sv]
// ----------------------------------------------------------------------------
// float32_to_narrow_grid_quantizer_unit: float32 to narrow grid rounding
// Input register, one combinational pass, result register.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid in_ready value_bits     | into block
//  out     | out_valid out_ready result_bits  | out of block
//  cfg     | cfg_we cfg_wdata                 | into block, format select
//
// One item per cycle while out_ready is high. The input register holds
// the item, the result register its result; the rounding logic between
// them is one pass. Reset clears valid flags and format to 0. A stalled
// result holds in its register; the input stage still advances as long
// as the result stage is free or being emptied.
module float32_to_narrow_grid_quantizer_unit import fngq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [FMT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] value_bits,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] result_bits
);

	logic [FMT_W-1:0]  fmt_q;
	logic              v_s1, v_s2;
	logic [DATA_W-1:0] x_s1, y_s2, y;
	ctl_t              ctl;
	logic              adv2, adv1;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= '0;
		else if (cfg_we) fmt_q <= cfg_wdata;
	end

	fngq_decode u_dec (.fmt(fmt_q), .ctl(ctl));
	fngq_core   u_core (.x(x_s1), .ctl(ctl), .y(y));

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) x_s1 <= value_bits;
		if (adv2 && v_s1)     y_s2 <= y;
	end

	assign out_valid   = v_s2;
	assign result_bits = y_s2;

endmodule

[hw/rtl/fngq_checker.sv]
// ----------------------------------------------------------------------------
// fngq_checker: port-level checks of the quantizer
// Bound to the top level.
// ----------------------------------------------------------------------------
module fngq_checker import fngq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] result_bits
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits))
		else $error("result changed under stall");

	// free output side always lets input in
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked with output free");

	// accepted item shows up at the output when never stalled
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
		else $error("item lost");

	// nothing out without input
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(in_valid && in_ready, 2))
		else $error("invented result");

endmodule

bind float32_to_narrow_grid_quantizer_unit fngq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
);

[tb/tb_float32_to_narrow_grid_quantizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float32_to_narrow_grid_quantizer_unit: self-checking quantizer bench
// Drives float32 patterns through every format, computes each grid value in
// a bit-level rounding model and compares the results in order of arrival.
// ----------------------------------------------------------------------------
module tb_float32_to_narrow_grid_quantizer_unit import fngq_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [FMT_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [DATA_W-1:0] value_bits;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] result_bits;

	// Input items waiting for the driver, and grid values waiting for the monitor
	logic [31:0] pending_values[$];
	logic [31:0] expected_grid[$];

	fmt_t cur_fmt;
	int   n_errors;
	int   n_checked;
	int   n_cycles;
	bit   quiet_tail;
	bit   long_hold;
	bit   in_fire;    // input item taken at the last rising edge
	int   send_gap;
	int   recv_gap;

	float32_to_narrow_grid_quantizer_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .value_bits(value_bits),
		.out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit is_nan(input logic [31:0] b);
		return b[30:0] > EXP_INF[30:0];
	endfunction

	function automatic int msb_pos(input logic [31:0] v);
		int p;
		p = -1;
		for (int i = 0; i < 32; i++)
			if (v[i]) p = i;
		return p;
	endfunction

	// Float grids: nearest-even on the mantissa, uniform step below the smallest normal
	function automatic logic [31:0] round_to_grid(input logic [31:0] x, input fmt_t f);
		int          man, tiny_e, s, e, r, p;
		logic [31:0] max_mag, neg, a, q, m, k, rem, half, big;
		ovf_t        ov;
		man = 3; tiny_e = -6; max_mag = 32'h43E0_0000; ov = OV_NAN;
		case (f)
			FMT_E5M2:        begin man = 2; tiny_e = -14; max_mag = 32'h4760_0000; ov = OV_INF; end
			FMT_E4M3:        begin man = 3; tiny_e = -6;  max_mag = 32'h4370_0000; ov = OV_INF; end
			FMT_E3M4:        begin man = 4; tiny_e = -2;  max_mag = 32'h4178_0000; ov = OV_INF; end
			FMT_E4M3B11FNUZ: begin man = 3; tiny_e = -10; max_mag = 32'h41F0_0000; ov = OV_NAN; end
			FMT_E5M2FNUZ:    begin man = 2; tiny_e = -15; max_mag = 32'h4760_0000; ov = OV_NAN; end
			FMT_E4M3FNUZ:    begin man = 3; tiny_e = -7;  max_mag = 32'h4370_0000; ov = OV_NAN; end
			FMT_E2M3:        begin man = 3; tiny_e = 0;   max_mag = 32'h40F0_0000; ov = OV_SAT; end
			FMT_E3M2:        begin man = 2; tiny_e = -2;  max_mag = 32'h41E0_0000; ov = OV_SAT; end
			FMT_E2M1:        begin man = 1; tiny_e = 0;   max_mag = 32'h40C0_0000; ov = OV_SAT; end
			default: ;
		endcase
		if (is_nan(x)) return x;
		neg = x & 32'h8000_0000;
		a = x & 32'h7FFF_FFFF;
		if (a < (32'(tiny_e + 127) << 23)) begin
			s = tiny_e - man;
			k = 0;
			if (a != 0) begin
				if (a[30:23] == 0) begin m = {9'd0, a[22:0]}; e = -149; end
				else begin m = {8'd0, 1'b1, a[22:0]}; e = int'(a[30:23]) - 150; end
				r = s - e;
				if (r >= 1 && r <= 25) begin
					rem = m & ((32'd1 << r) - 1);
					half = 32'd1 << (r - 1);
					k = m >> r;
					if (rem > half || (rem == half && k[0])) k++;
				end
			end
			if (k == 0) q = neg;
			else begin
				p = msb_pos(k);
				q = neg | (32'(p + s + 127) << 23) | ((k << (23 - p)) & 32'h007F_FFFF);
			end
		end else begin
			s = 23 - man;
			q = (x + ((32'd1 << (s - 1)) - 1) + ((x >> s) & 1)) & ~((32'd1 << s) - 1);
		end
		if ((q & 32'h7FFF_FFFF) > max_mag) begin
			case (ov)
				OV_INF:  big = EXP_INF;
				OV_SAT:  big = max_mag;
				default: big = QNAN_BITS;
			endcase
			q = neg | big;
		end
		return q;
	endfunction

	// Nearest power of two, split at sqrt(2)
	function automatic logic [31:0] round_to_pow2(input logic [31:0] x);
		logic [31:0] m;
		int          e, p;
		if (is_nan(x)) return x;
		if (x[31] || x == 0) return E8M0_MIN;
		if (x == EXP_INF) return EXP_INF;
		if (x[30:23] == 0) begin m = {9'd0, x[22:0]}; e = -149; end
		else begin m = {8'd0, 1'b1, x[22:0]}; e = int'(x[30:23]) - 150; end
		p = msb_pos(m);
		e += p;
		m = (m << (23 - p)) & 32'h007F_FFFF;
		if (m[22:0] >= SQRT2_MAN) e++;
		if (e < -127) e = -127;
		if (e >= 128) return EXP_INF;
		if (e == -127) return E8M0_MIN;
		return 32'(e + 127) << 23;
	endfunction

	// Truncate toward zero with int32 saturation; NaN gives zero
	function automatic logic [31:0] trunc_int32(input logic [31:0] x);
		logic [31:0] m, mag;
		int          e;
		if (is_nan(x) || x[30:0] < 31'h3F80_0000) return 0;
		e = int'(x[30:23]) - 127;
		if (e >= 31) return x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		m = {8'd0, 1'b1, x[22:0]};
		mag = (e >= 23) ? (m << (e - 23)) : (m >> (23 - e));
		return x[31] ? (0 - mag) : mag;
	endfunction

	function automatic logic [31:0] quantize(input logic [31:0] x, input fmt_t f);
		logic [31:0] t;
		case (f)
			FMT_E8M0:  return round_to_pow2(x);
			FMT_INT4:  begin t = trunc_int32(x); return {{28{t[3]}}, t[3:0]}; end
			FMT_UINT4: begin t = trunc_int32(x); return {28'd0, t[3:0]}; end
			FMT_RSV13, FMT_RSV14, FMT_RSV15: return x;
			default:   return round_to_grid(x, f);
		endcase
	endfunction

	// Random float32 mostly near the grid ranges, with some raw patterns
	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
			0, 1: v[30:23] = 8'($urandom_range(100, 150));
			2:    v[30:23] = 8'($urandom_range(110, 135));
			3:    v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			4:    v[30:23] = 8'($urandom_range(120, 131));
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) v[19:0] = $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
		return v;
	endfunction

	// Driver: offers the next pending item, holds it until accepted
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire && send_gap == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 6);
			if (!in_valid || in_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_values.size() > 0) begin
					value_bits <= pending_values.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver readiness: random bursts of stall, one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= (recv_gap == 0);
			end else if (long_hold) begin
				long_hold = 1'b0;
				recv_gap = 60;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 6);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// Monitor: compare each accepted result with the oldest expected value
	always @(posedge clk) begin
		if (arst_n) begin
			n_cycles++;
			in_fire = in_valid && in_ready;
			if (in_fire)
				expected_grid.push_back(quantize(value_bits, cur_fmt));
			if (out_valid && out_ready) begin
				if (expected_grid.size() == 0) begin
					$error("result_bits: unexpected item, actual %h", result_bits);
					n_errors++;
				end else begin
					logic [31:0] want;
					want = expected_grid.pop_front();
					n_checked++;
					if (result_bits !== want) begin
						$error("result_bits: expected %h actual %h", want, result_bits);
						n_errors++;
					end
				end
			end
			if (n_cycles > CYCLE_LIMIT) begin
				$display("cycle limit reached with %0d items outstanding",
					expected_grid.size());
				$display("** float32_to_narrow_grid_quantizer_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_values.size() > 0 || in_valid || expected_grid.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_format(input fmt_t f);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= f;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_fmt = f;
	endtask

	initial begin
		logic [31:0] corners[$];
		fmt_t        f;
		n_errors = 0; n_checked = 0; n_cycles = 0;
		quiet_tail = 1'b0; long_hold = 1'b0; in_fire = 1'b0; send_gap = 0; recv_gap = 0;
		cur_fmt = FMT_E4M3FN;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
		in_valid = 1'b0; value_bits = '0; out_ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Corners: zeros, subnormals, tie points, huge values, infinities, NaNs
		corners = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
			32'h3C80_0000, 32'h3B00_0000, 32'h3F88_0000, 32'h3F98_0000,
			32'h3FB5_04F3, 32'h3FB5_04F4, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
			32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
			32'h43E8_0000, 32'h4F00_0000, 32'hCF00_0001, 32'h40E0_0000,
			32'hC100_0000, 32'h3F7F_FFFF, 32'h0080_0000};

		// Reset value first, then every format with the corners
		foreach (corners[i]) pending_values.push_back(corners[i]);
		drain();
		for (int s = 1; s < 16; s++) begin
			set_format(fmt_t'(s));
			foreach (corners[i]) pending_values.push_back(corners[i]);
			drain();
		end

		// Random phases through formats 0 to 12 and code 15, with one long receiver hold-off
		for (int ph = 0; ph < 16; ph++) begin
			f = (ph == 15) ? FMT_RSV15 : fmt_t'(ph < 13 ? ph : $urandom_range(0, 12));
			set_format(f);
			if (ph == 3) long_hold = 1'b1;
			if (ph >= 13) quiet_tail = 1'b1;
			for (int i = 0; i < 6; i++) pending_values.push_back(rand_value());
			drain();
		end

		$display("checked %0d results over all 16 format codes, corner and random values",
			n_checked);
		if (n_errors == 0)
			$display("** float32_to_narrow_grid_quantizer_unit: PASSED **");
		else
			$display("** float32_to_narrow_grid_quantizer_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/fngq_pkg.sv
hw/rtl/fngq_decode.sv
hw/rtl/fngq_core.sv
hw/rtl/float32_to_narrow_grid_quantizer_unit.sv
hw/rtl/fngq_checker.sv
tb/tb_float32_to_narrow_grid_quantizer_unit.sv
